// File: sv/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

   localparam int DATA_W = 32;
   localparam int FREQ_W = 16;
   localparam int DUR_W  = 16;
   localparam int LEN_W  = 9;
   localparam int SLOT_W = 8;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_START   = 2'd1;
   localparam logic [1:0] CMD_PROCESS = 2'd2;
   localparam logic [1:0] CMD_NOP     = 2'd3;

   localparam logic [1:0] REG_CLOCK_HZ  = 2'd0;
   localparam logic [1:0] REG_MAX_COUNT = 2'd1;
   localparam logic [1:0] REG_SOUND_EN  = 2'd2;

   localparam logic [DATA_W-1:0] CLOCK_HZ_RESET  = 32'd1000000;
   localparam logic [FREQ_W-1:0] MAX_COUNT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]        command;
      logic [SLOT_W-1:0] note_index;
      logic [FREQ_W-1:0] note_frequency;
      logic [DUR_W-1:0]  note_duration;
      logic [LEN_W-1:0]  sequence_length;
      logic [DATA_W-1:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic              prescaler_write;
      logic [DATA_W-1:0] prescaler_value;
      logic              tone_playing;
      logic              sequence_done;
      logic [LEN_W-1:0]  note_position;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// File: sv/tsp_ram.sv
`default_nettype none

module tsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/tsp_div.sv
`default_nettype none

module tsp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tsp_pkg::DATA_W-1:0]   dividend,
   input  logic [tsp_pkg::FREQ_W-1:0]   factor_a,
   input  logic [tsp_pkg::FREQ_W-1:0]   factor_b,
   output tsp_pkg::div_status_type      status,
   output logic [tsp_pkg::DATA_W-1:0]   quotient
);

   import tsp_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic                busy_ff, busy_in;
   logic                mul_pend_ff, mul_pend_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [FREQ_W-1:0]   a_ff, a_in;
   logic [FREQ_W-1:0]   b_ff, b_in;
   logic [DATA_W-1:0]   divisor_ff, divisor_in;
   logic [DATA_W-1:0]   rem_ff, rem_in;
   logic [DATA_W-1:0]   quot_ff, quot_in;
   logic [DATA_W:0]     shifted;
   logic [DATA_W:0]     diff;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quot_ff[DATA_W-1]};
   assign diff    = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in     = busy_ff;
      mul_pend_in = mul_pend_ff;
      done_in     = 1'b0;
      count_in    = count_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      divisor_in  = divisor_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      if (start && !busy_ff) begin
         busy_in     = 1'b1;
         mul_pend_in = 1'b1;
         a_in        = factor_a;
         b_in        = factor_b;
         rem_in      = '0;
         quot_in     = dividend;
         count_in    = '0;
      end else if (busy_ff && mul_pend_ff) begin
         divisor_in  = DATA_W'({16'd0, a_ff} * {16'd0, b_ff});
         mul_pend_in = 1'b0;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in  = diff[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DATA_W-1:0];
            quot_in = {quot_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         mul_pend_ff <= 1'b0;
         done_ff     <= 1'b0;
         count_ff    <= '0;
      end else begin
         busy_ff     <= busy_in;
         mul_pend_ff <= mul_pend_in;
         done_ff     <= done_in;
         count_ff    <= count_in;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider busy while reporting done");

   a_mul_first: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> (busy_ff && mul_pend_ff))
      else $error("divider did not begin with the product cycle");

endmodule

`default_nettype wire

// File: sv/tone_sequence_player_top.sv
`default_nettype none

// tone sequence player: steps through a stored list of (frequency, duration) notes
// and reports the tone timer prescaler writes that each transaction causes.
// req channel (valid/stall): one command per transaction. write stores a note entry,
// start sets length and rewinds if sound is on; process carries the millisecond tick.
// rsp channel (valid/stall): exactly one result per request transaction.
// csr port: APB-style, timer_clock_hz at 0x0, timer_max_count at 0x4, sound_enabled at
// 0x8; write only while no transaction is in flight.
// write, start and no-op go from accept straight to the reply step, as does a process
// step with no sequence left; otherwise it passes the evaluate step, and one that starts
// a tone then runs the divider (a product step, then one quotient bit per cycle for 32
// bits) before the reply, after a second evaluate if the previous note is silenced.
// only one transaction is worked on at a time; req_stall stays high until its result
// sits in the output register.
// a stalled rsp holds its payload; the block still accepts and works the next request,
// then waits in the reply step for the output register to drain.
// reset clears the sequence state (no sequence, position 0, silent) and restores the
// csr defaults; the note memory keeps its contents and has no clear pass.
module tone_sequence_player_top #(
   parameter int NOTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tsp_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tsp_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tsp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tsp_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [tsp_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   import tsp_pkg::*;

   localparam int AW = $clog2(NOTE_DEPTH);
   localparam int PW = $clog2(NOTE_DEPTH + 1);
   localparam int ENTRY_W = FREQ_W + DUR_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EVAL  = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [PW-1:0]      position_ff, position_in;
   logic [PW-1:0]      length_ff, length_in;
   logic               active_ff, active_in;
   logic               loaded_ff, loaded_in;
   logic [DATA_W-1:0]  start_ff, start_in;
   logic [DATA_W-1:0]  now_ff, now_in;
   logic               wrote_ff, wrote_in;
   logic [DATA_W-1:0]  pres_ff, pres_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;
   logic [DATA_W-1:0]  clock_hz_ff;
   logic [FREQ_W-1:0]  max_count_ff;
   logic               sound_ff;

   logic               accept;
   logic               out_free;
   logic               csr_write;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [ENTRY_W-1:0] rd_entry;
   logic [FREQ_W-1:0]  entry_freq;
   logic [DUR_W-1:0]   entry_dur;
   logic [DATA_W-1:0]  elapsed;
   logic [PW-1:0]      position_inc;
   logic               div_start;
   div_status_type     div_status;
   logic [DATA_W-1:0]  div_quotient;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // note memory: frequency in the upper half, duration in the lower half
   assign wr_en   = accept && (req_payload.command == CMD_WRITE)
                    && ({24'd0, req_payload.note_index} < 32'(NOTE_DEPTH));
   assign wr_addr = AW'({24'd0, req_payload.note_index});
   // read the entry of the next position, so it is ready in the next cycle
   assign rd_addr = AW'(position_in);

   tsp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NOTE_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_payload.note_frequency, req_payload.note_duration}),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign entry_freq   = rd_entry[ENTRY_W-1:DUR_W];
   assign entry_dur    = rd_entry[DUR_W-1:0];
   assign elapsed      = now_ff - start_ff;
   assign position_inc = position_ff + 1'b1;

   tsp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (clock_hz_ff),
      .factor_a (max_count_ff),
      .factor_b (entry_freq),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      position_in  = position_ff;
      length_in    = length_ff;
      active_in    = active_ff;
      loaded_in    = loaded_ff;
      start_in     = start_ff;
      now_in       = now_ff;
      wrote_in     = wrote_ff;
      pres_in      = pres_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wrote_in = 1'b0;
               pres_in  = '0;
               now_in   = req_payload.now_ms;
               state_in = ST_REPLY;
               case (req_payload.command)
                  CMD_START: begin
                     if (sound_ff) begin
                        if ({23'd0, req_payload.sequence_length} > 32'(NOTE_DEPTH)) begin
                           length_in = PW'(NOTE_DEPTH);
                        end else begin
                           length_in = PW'(req_payload.sequence_length);
                        end
                        position_in = '0;
                        active_in   = 1'b0;
                        loaded_in   = 1'b1;
                     end
                  end
                  CMD_PROCESS: begin
                     if (loaded_ff && (position_ff < length_ff)) begin
                        state_in = ST_EVAL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EVAL: begin
            if (active_ff) begin
               if (elapsed >= {16'd0, entry_dur}) begin
                  wrote_in    = 1'b1;
                  pres_in     = '0;
                  active_in   = 1'b0;
                  position_in = position_inc;
                  // next entry arrives next cycle; evaluate again to start it
                  state_in    = (position_inc < length_ff) ? ST_EVAL : ST_REPLY;
               end else begin
                  state_in = ST_REPLY;
               end
            end else begin
               start_in  = now_ff;
               active_in = 1'b1;
               if (entry_freq != '0) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               wrote_in = 1'b1;
               pres_in  = div_quotient;
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_in.prescaler_write      = wrote_ff;
               rsp_in.prescaler_value      = pres_ff;
               rsp_in.tone_playing         = active_ff;
               rsp_in.sequence_done        = (position_ff >= length_ff);
               rsp_in.note_position        = LEN_W'(position_ff);
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         position_ff  <= '0;
         length_ff    <= '0;
         active_ff    <= 1'b0;
         loaded_ff    <= 1'b0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         clock_hz_ff  <= CLOCK_HZ_RESET;
         max_count_ff <= MAX_COUNT_RESET;
         sound_ff     <= 1'b1;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         length_ff    <= length_in;
         active_ff    <= active_in;
         loaded_ff    <= loaded_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_paddr[3:2])
               REG_CLOCK_HZ:  clock_hz_ff  <= csr_pwdata;
               REG_MAX_COUNT: max_count_ff <= csr_pwdata[FREQ_W-1:0];
               REG_SOUND_EN:  sound_ff     <= csr_pwdata[0];
               default: begin
               end
            endcase
         end
      end
      now_ff   <= now_in;
      wrote_ff <= wrote_in;
      pres_ff  <= pres_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_CLOCK_HZ:  csr_prdata = clock_hz_ff;
         REG_MAX_COUNT: csr_prdata = {16'd0, max_count_ff};
         REG_SOUND_EN:  csr_prdata = {31'd0, sound_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("result appeared outside the reply step");

   a_active_needs_sequence: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> loaded_ff)
      else $error("note timed without a started sequence");

   a_position_bounded: assert property (@(posedge clock) disable iff (reset)
      position_ff <= length_ff)
      else $error("position ran past the sequence length");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("division finished outside the divide step");

   a_silent_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.prescaler_write) |-> (rsp_ff.prescaler_value == '0))
      else $error("prescaler value without a prescaler write");

endmodule

`default_nettype wire
